>>> design/oss_pkg.sv
// Shared types, constants and fixed-point helpers for the seawater oxygen
// solubility pipeline. No dependencies.
`default_nettype none

package oss_pkg;

  // Output scaling: saturation is in 2^-OUT_FRAC_BITS mol/m^3
  localparam int OUT_FRAC_BITS = 20;

  // Hot-water clamp point, 40 C in 1/256 degree units
  localparam logic signed [14:0] T_MAX = 15'sd10240;

  localparam logic [19:0] SAT_MAX = 20'hFFFFF;

  // ln(2) in Q30
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // Fit coefficients in Q30, index is the power of scaled temperature
  localparam logic signed [35:0] A_Q30 [6] = '{
    36'sd2157222486, 36'sd3457598997, 36'sd4348761761,
    36'sd5309191611, -36'sd275787366, 36'sd4174353877
  };
  localparam logic signed [27:0] B_Q30 [4] = '{
    -28'sd6705765, -28'sd7920070, -28'sd11103564, -28'sd8773362
  };
  // Magnitude of the salinity-squared coefficient in Q52
  localparam logic [31:0] C0_MAG_Q52 = 32'd2200828073;

  // Floor of x/d for a constant d: multiply by m = floor(2^s/d), then one
  // correction step. Exact whenever x < 2^s.
  function automatic logic [63:0] udiv_c(input logic [63:0] x, input logic [63:0] d,
                                         input logic [63:0] m, input logic [5:0] s);
    logic [63:0] q;
    logic [63:0] r;
    q = (x * m) >> s;
    r = x - q * d;
    if (r >= d) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  // Signed shift right by s with round to nearest, ties away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] x,
                                              input logic [5:0] s);
    logic [63:0] mag;
    logic [63:0] q;
    mag = x[63] ? 64'(-x) : 64'(x);
    q = (mag + (64'd1 << (s - 6'd1))) >> s;
    return x[63] ? -$signed(q) : $signed(q);
  endfunction

  // Q30 product, rounded back to Q30
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return rshr(a * b, 6'd30);
  endfunction

endpackage

`default_nettype wire

>>> design/oss_in_if.sv
// Input channel: one temperature and salinity sample per transfer.
// Standalone interface, no dependencies.
`default_nettype none

interface oss_in_if;
  logic                valid;
  logic                ready;
  logic signed [14:0]  temperature;
  logic        [13:0]  salinity;

  modport source(output valid, temperature, salinity, input ready);
  modport sink(input valid, temperature, salinity, output ready);
endinterface

`default_nettype wire

>>> design/oss_out_if.sv
// Output channel: one saturation concentration and clamp flag per transfer.
// Standalone interface, no dependencies.
`default_nettype none

interface oss_out_if;
  logic         valid;
  logic         ready;
  logic [19:0]  saturation;
  logic         temp_clamped;

  modport source(output valid, saturation, temp_clamped, input ready);
  modport sink(input valid, saturation, temp_clamped, output ready);
endinterface

`default_nettype wire

>>> design/oss_exp.sv
// Pipelined exponential: splits w into k*ln2 + r and sums the Taylor series
// of exp(r) to the 13th term. Uses oss_pkg helpers. 28 register stages.
`default_nettype none

module oss_exp
  import oss_pkg::*;
(
  input  logic               clk,
  input  logic               ce,
  input  logic signed [36:0] w,
  output logic signed [7:0]  k,
  output logic        [31:0] ex
);

  // Offset in multiples of ln2 so the range reduction works on a positive value
  localparam int KOFF = 16;
  localparam logic [37:0] XOFF = 38'(KOFF) * 38'(LN2_Q30);
  localparam logic [63:0] KM = (64'd1 << 38) / 64'(LN2_Q30);

  logic [37:0] xw;
  logic [63:0] kq;
  logic [37:0] x1;
  logic [7:0]  kp1;

  logic [29:0]        r_a    [1:12];
  logic signed [7:0]  k_a    [1:13];
  logic [31:0]        sum_a  [1:13];
  logic [30:0]        ph     [1:13];
  logic [29:0]        r_b    [0:12];
  logic signed [7:0]  k_b    [0:13];
  logic [31:0]        sum_b  [0:13];
  logic [30:0]        term_b [0:12];

  // Range reduction: k' = floor((w + KOFF*ln2) / ln2)
  assign xw = 38'($signed(38'(w)) + $signed(XOFF));
  assign kq = udiv_c(64'(xw), 64'(LN2_Q30), KM, 6'd38);

  always_ff @(posedge clk) begin
    if (ce) begin
      x1  <= xw;
      kp1 <= kq[7:0];
    end
  end

  // Remainder r in [0, ln2), seed the series with 1.0
  always_ff @(posedge clk) begin
    if (ce) begin
      r_b[0]    <= 30'(x1 - 38'(kp1) * 38'(LN2_Q30));
      k_b[0]    <= $signed(kp1) - 8'sd16;
      term_b[0] <= 31'd1 << 30;
      sum_b[0]  <= 32'd1 << 30;
    end
  end

  // One term per two stages: multiply, then divide by n
  for (genvar n = 1; n <= 13; n++) begin : g_term
    localparam logic [63:0] ND = 64'(n);
    localparam logic [63:0] NM = (64'd1 << 31) / ND;
    logic [63:0] prod;
    logic [63:0] tq;

    assign prod = 64'(term_b[n-1]) * 64'(r_b[n-1]) + (ND << 29);
    assign tq   = udiv_c(64'(ph[n]), ND, NM, 6'd31);

    always_ff @(posedge clk) begin
      if (ce) begin
        ph[n]    <= prod[60:30];
        sum_a[n] <= sum_b[n-1];
        k_a[n]   <= k_b[n-1];
        sum_b[n] <= sum_a[n] + 32'(tq[30:0]);
        k_b[n]   <= k_a[n];
      end
    end

    if (n < 13) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          r_a[n]    <= r_b[n-1];
          term_b[n] <= tq[30:0];
          r_b[n]    <= r_a[n];
        end
      end
    end
  end

  assign k  = k_b[13];
  assign ex = sum_b[13];

endmodule

`default_nettype wire

>>> design/oxygen_solubility_seawater_core.sv
// Top level of the seawater oxygen solubility pipeline.
// Depends on oss_pkg, oss_in_if, oss_out_if and oss_exp.
//
// Usage:
//   samples (sink): temperature in 1/256 C (signed), salinity in 1/256 PSU.
//   results (source): saturation in 2^-20 mol/m^3, saturating at full
//   scale, and temp_clamped, set when the sample was above 40 C.
//   One result per sample, in order.
// Throughput: one sample per cycle while the pipeline is not stalled, fully pipelined.
// Depth: 53 register stages. The depth is set by the 13-term exponential
//   series, which needs a multiply stage and a divide stage per term.
// Stall: the whole pipeline holds while the output register is full and
//   results.ready is low; samples.ready is low in exactly those cycles.
//   Bubbles travel as cleared valid bits.
// Reset: rst clears all valid bits; no clearing pass is needed, samples are
//   accepted as soon as rst is low.
`default_nettype none

module oxygen_solubility_seawater_core
  import oss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  oss_in_if.sink   samples,
  oss_out_if.source results
);

  localparam int LAT = 53;

  // Reciprocals for the constant divisions
  localparam logic [63:0] ZM1 = (64'd1 << 20) / 64'd5713;
  localparam logic [63:0] ZM2 = (64'd1 << 34) / 64'd5713;
  localparam logic [63:0] MD1 = (64'd1 << 32) / 64'd55979;
  localparam logic [63:0] MD2 = (64'd1 << 28) / 64'd55979;
  localparam logic signed [8:0] SFT_BASE = 9'(30 - OUT_FRAC_BITS);

  logic           ce;
  logic [LAT-1:0] vld;
  logic [LAT-1:0] clp;
  logic [13:0]    sal [0:17];

  logic signed [14:0] t0;
  logic signed [21:0] num1;
  logic        [21:0] absn;
  logic        [63:0] qh_c;
  logic        [7:0]  qh1;
  logic        [12:0] rh1;
  logic               neg1;
  logic        [33:0] xz;
  logic        [63:0] q2_c;
  logic        [28:0] zmag;
  logic signed [29:0] z2;
  logic signed [63:0] zz_c;

  logic signed [29:0] ser_term [0:10];
  logic signed [30:0] ser_sum  [0:11];
  logic        [27:0] ser_zz   [0:9];
  logic signed [31:0] ts14;

  logic signed [31:0] h_ts [1:4];
  logic signed [35:0] pa   [1:5];
  logic signed [27:0] pb   [1:3];
  logic signed [63:0] pa1_c;
  logic signed [63:0] pb1_c;
  logic        [27:0] ss15;
  logic        [63:0] c_c;
  logic        [21:0] c16;
  logic        [21:0] c17;
  logic        [21:0] c18;
  logic signed [63:0] salt_c;
  logic signed [31:0] salt18;
  logic signed [32:0] corr19;
  logic signed [36:0] w20;

  logic signed [7:0]  k48;
  logic        [31:0] ex48;
  logic        [63:0] q1_c;
  logic        [16:0] q49;
  logic        [15:0] r49;
  logic signed [8:0]  sft49;
  logic        [16:0] q50;
  logic        [27:0] x50;
  logic signed [8:0]  sft50;
  logic        [63:0] q3_c;
  logic        [27:0] qd51;
  logic signed [8:0]  sft51;
  logic        [32:0] rq;
  logic        [19:0] sat_next;
  logic        [19:0] sat52;

  // Advance everything unless a finished result is waiting
  assign ce            = !vld[LAT-1] || results.ready;
  assign samples.ready = ce;

  // Valid bits and side data travel with the items
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], samples.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      clp    <= {clp[LAT-2:0], (samples.temperature > T_MAX)};
      sal[0] <= samples.salinity;
      for (int i = 1; i < 18; i++) begin
        sal[i] <= sal[i-1];
      end
    end
  end

  // Stage 0: clamp temperature
  always_ff @(posedge clk) begin
    if (ce) begin
      t0 <= (samples.temperature > T_MAX) ? T_MAX : samples.temperature;
    end
  end

  // Stages 1-2: z = (128000 - 40 t) / 2925056 in Q30, split in two divisions
  assign num1 = 22'sd128000 - 22'sd40 * 22'(t0);
  assign absn = num1[21] ? 22'(-num1) : 22'(num1);
  assign qh_c = udiv_c(64'(absn[19:0]), 64'd5713, ZM1, 6'd20);

  always_ff @(posedge clk) begin
    if (ce) begin
      qh1  <= qh_c[7:0];
      rh1  <= 13'(absn[19:0] - 20'(qh_c[7:0]) * 20'd5713);
      neg1 <= num1[21];
    end
  end

  assign xz   = {rh1, 21'd0} + 34'd2856;
  assign q2_c = udiv_c(64'(xz), 64'd5713, ZM2, 6'd34);
  assign zmag = {qh1, q2_c[20:0]};

  always_ff @(posedge clk) begin
    if (ce) begin
      z2 <= neg1 ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
    end
  end

  // Stage 3: square of z, seed the series
  assign zz_c = qmul(64'(z2), 64'(z2));

  always_ff @(posedge clk) begin
    if (ce) begin
      ser_term[0] <= z2;
      ser_sum[0]  <= '0;
      ser_zz[0]   <= zz_c[27:0];
    end
  end

  // Stages 4-14: atanh series, one odd power per stage
  for (genvar j = 1; j <= 11; j++) begin : g_ser
    localparam logic [63:0] SD = 64'(2 * j - 1);
    localparam logic [63:0] SM = (64'd1 << 30) / SD;
    logic        [29:0] tmag;
    logic        [63:0] tq;
    logic signed [30:0] tdiv;

    assign tmag = ser_term[j-1][29] ? 30'(-ser_term[j-1]) : 30'(ser_term[j-1]);
    assign tq   = udiv_c(64'(tmag) + 64'(j - 1), SD, SM, 6'd30);
    assign tdiv = ser_term[j-1][29] ? -$signed({1'b0, tq[29:0]})
                                    : $signed({1'b0, tq[29:0]});

    always_ff @(posedge clk) begin
      if (ce) begin
        ser_sum[j] <= ser_sum[j-1] + tdiv;
      end
    end

    if (j <= 10) begin : g_pow
      logic signed [63:0] tp;
      assign tp = qmul(64'(ser_term[j-1]), $signed({36'd0, ser_zz[j-1]}));
      always_ff @(posedge clk) begin
        if (ce) begin
          ser_term[j] <= tp[29:0];
        end
      end
    end

    if (j <= 9) begin : g_zz
      always_ff @(posedge clk) begin
        if (ce) begin
          ser_zz[j] <= ser_zz[j-1];
        end
      end
    end
  end

  assign ts14 = {ser_sum[11], 1'b0};

  // Stages 15-19: Horner evaluation of both polynomials
  assign pa1_c = qmul(64'(A_Q30[5]), 64'(ts14));
  assign pb1_c = qmul(64'(B_Q30[3]), 64'(ts14));

  always_ff @(posedge clk) begin
    if (ce) begin
      h_ts[1] <= ts14;
      pa[1]   <= 36'(pa1_c) + A_Q30[4];
      pb[1]   <= 28'(pb1_c) + B_Q30[2];
    end
  end

  for (genvar j = 2; j <= 5; j++) begin : g_pa
    logic signed [63:0] hp;
    assign hp = qmul(64'(pa[j-1]), 64'(h_ts[j-1]));
    always_ff @(posedge clk) begin
      if (ce) begin
        pa[j] <= 36'(hp) + A_Q30[5-j];
      end
    end
  end

  for (genvar j = 2; j <= 4; j++) begin : g_ts
    always_ff @(posedge clk) begin
      if (ce) begin
        h_ts[j] <= h_ts[j-1];
      end
    end
  end

  for (genvar j = 2; j <= 3; j++) begin : g_pb
    logic signed [63:0] hp;
    assign hp = qmul(64'(pb[j-1]), 64'(h_ts[j-1]));
    always_ff @(posedge clk) begin
      if (ce) begin
        pb[j] <= 28'(hp) + B_Q30[3-j];
      end
    end
  end

  // Salinity terms, then the exponent w
  assign c_c    = (64'(C0_MAG_Q52) * 64'(ss15) + (64'd1 << 37)) >> 38;
  assign salt_c = rshr(64'(pb[3]) * $signed({50'd0, sal[17]}), 6'd8);

  always_ff @(posedge clk) begin
    if (ce) begin
      ss15   <= 28'(sal[14]) * 28'(sal[14]);
      c16    <= c_c[21:0];
      c17    <= c16;
      c18    <= c17;
      salt18 <= salt_c[31:0];
      corr19 <= 33'(salt18) - $signed({11'd0, c18});
      w20    <= 37'(pa[5]) + 37'(corr19);
    end
  end

  // Stages 21-48: exponential
  oss_exp u_exp (
    .clk (clk),
    .ce  (ce),
    .w   (w20),
    .k   (k48),
    .ex  (ex48)
  );

  // Stages 49-51: floor(exp * 10000 / 223916) as two small divisions
  assign q1_c = udiv_c(64'(ex48), 64'd55979, MD1, 6'd32);
  assign q3_c = udiv_c(64'(x50), 64'd55979, MD2, 6'd28);

  always_ff @(posedge clk) begin
    if (ce) begin
      q49   <= q1_c[16:0];
      r49   <= 16'(ex48 - 32'(q1_c[16:0]) * 32'd55979);
      sft49 <= SFT_BASE - 9'(k48);
      q50   <= q49;
      x50   <= 28'(r49) * 28'd2500;
      sft50 <= sft49;
      qd51  <= 28'(q50) * 28'd2500 + q3_c[27:0];
      sft51 <= sft50;
    end
  end

  // Stage 52: final rounding shift and saturation
  always_comb begin
    rq       = '0;
    sat_next = '0;
    priority if (sft51 <= 9'sd0) begin
      sat_next = SAT_MAX;
    end else if (sft51 > 9'sd28) begin
      sat_next = '0;
    end else begin
      rq = (33'(qd51) + (33'd1 << (sft51[4:0] - 5'd1))) >> sft51[4:0];
      sat_next = (rq > 33'(SAT_MAX)) ? SAT_MAX : rq[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sat52 <= sat_next;
    end
  end

  assign results.valid        = vld[LAT-1];
  assign results.saturation   = sat52;
  assign results.temp_clamped = clp[LAT-1];

  // A transfer in always enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> vld[0])
    else $error("accepted sample did not enter the pipeline");

  // A waiting result blocks new samples
  a_block: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |-> !samples.ready)
    else $error("sample taken while output stalled");

  // A stall freezes the valid bits
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !ce |=> (vld == $past(vld)))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

>>> tb/oxygen_solubility_seawater_core_tb.sv
// Testbench for oxygen_solubility_seawater_core: directed samples, then random ones,
// each result checked against a bit-exact fixed-point solubility predictor.
// Depends on oss_pkg, oss_in_if, oss_out_if and the core itself.
`default_nettype none

module oxygen_solubility_seawater_core_tb;
  import oss_pkg::*;

  localparam int NUM_RANDOM    = 1500;
  localparam int DRAIN_CYCLES  = 60;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLDOFF_LEN   = 200;
  localparam int HOLDOFF_AT    = 400;
  localparam int CALM_FROM     = 1300;
  localparam int MAX_REPORTS   = 10;

  localparam longint ONE_Q = longint'(1) << 30;
  localparam longint LN2_Q = 744261118;
  localparam longint C0_MAG = 64'sd2200828073;
  localparam longint A_COEF [6] = '{64'sd2157222486, 64'sd3457598997, 64'sd4348761761,
                                    64'sd5309191611, -64'sd275787366, 64'sd4174353877};
  localparam longint B_COEF [4] = '{-6705765, -7920070, -11103564, -8773362};

  typedef struct packed {
    logic [19:0] saturation;
    logic        temp_clamped;
  } solubility_t;

  typedef struct {
    logic signed [14:0] temperature;
    logic        [13:0] salinity;
    logic               clamp_known;
  } sample_row_t;

  logic clk;
  logic rst;

  oss_in_if  smp();
  oss_out_if res();

  oxygen_solubility_seawater_core u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (smp),
    .results (res)
  );

  solubility_t expected_q[$];
  int          mismatches;
  int          sent;
  int          received;
  logic        calm;
  logic        holdoff;

  // Directed samples: extremes, clamp boundary, bit patterns
  sample_row_t dir_rows [] = '{
    '{15'sd0,      14'd0,     1'b1},
    '{15'sh4000,   14'd0,     1'b1},
    '{15'sh4000,   14'd16383, 1'b1},
    '{15'sd16383,  14'd16383, 1'b1},
    '{15'sd16383,  14'd0,     1'b1},
    '{15'sd10240,  14'd12800, 1'b1},
    '{15'sd10241,  14'd12800, 1'b1},
    '{15'sd10239,  14'd0,     1'b1},
    '{-15'sd1280,  14'd12800, 1'b1},
    '{-15'sd1280,  14'd0,     1'b1},
    '{15'sd5120,   14'd8960,  1'b1},
    '{-15'sd1,     14'd1,     1'b1},
    '{15'sd10922,  14'd10922, 1'b1},
    '{-15'sd10923, 14'd5461,  1'b1},
    '{15'sd64,     14'd16383, 1'b1},
    '{15'sd2560,   14'd9000,  1'b1}
  };

  // Divide rounding to nearest, ties away from zero
  function automatic longint round_div(longint n, longint d);
    longint unsigned mag;
    longint unsigned q;
    mag = n < 0 ? longint'(0) - n : n;
    q = (mag + longint'(d / 2)) / d;
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return round_div(a * b, ONE_Q);
  endfunction

  // Saturation concentration for one sample
  function automatic solubility_t predict_solubility(logic signed [14:0] temperature,
                                                     logic [13:0] salinity);
    solubility_t r;
    longint t, s, z, z2, term, sum, ts, pa, pb, w, k, sh;
    longint unsigned rem, esum, eterm, mm, den, q;
    t = temperature;
    s = salinity;
    r.temp_clamped = 1'b0;
    if (t > 10240) begin
      t = 10240;
      r.temp_clamped = 1'b1;
    end
    // scaled temperature by the atanh series
    z = round_div((128000 - 40 * t) * ONE_Q, 2925056);
    z2 = q30_mul(z, z);
    term = z;
    sum = z;
    for (int i = 1; i <= 10; i++) begin
      term = q30_mul(term, z2);
      sum += round_div(term, 2 * i + 1);
    end
    ts = 2 * sum;
    pa = A_COEF[5];
    for (int i = 4; i >= 0; i--) pa = q30_mul(pa, ts) + A_COEF[i];
    pb = B_COEF[3];
    for (int i = 2; i >= 0; i--) pb = q30_mul(pb, ts) + B_COEF[i];
    w = pa + round_div(pb * s, 256) - round_div(C0_MAG * (s * s), longint'(1) << 38);
    // split off powers of two, then the Taylor series
    if (w >= 0) k = w / LN2_Q;
    else k = -((-w + LN2_Q - 1) / LN2_Q);
    rem = w - k * LN2_Q;
    esum = ONE_Q;
    eterm = ONE_Q;
    for (longint unsigned n = 1; n <= 13; n++) begin
      eterm = (eterm * rem + (n << 29)) / (n << 30);
      esum += eterm;
    end
    sh = k + OUT_FRAC_BITS - 30;
    if (sh >= 0) begin
      r.saturation = 20'hFFFFF;
    end else if (sh < -44) begin
      r.saturation = '0;
    end else begin
      mm = esum * 10000;
      den = longint'(223916) << (-sh);
      q = (mm + den / 2) / den;
      r.saturation = q > 1048575 ? 20'hFFFFF : q[19:0];
    end
    return r;
  endfunction

  // Offer one sample, hold until transferred, queue its expectation
  task automatic send_sample(logic signed [14:0] temperature, logic [13:0] salinity,
                             logic clamp_known);
    solubility_t exp_item;
    smp.valid       <= 1'b1;
    smp.temperature <= temperature;
    smp.salinity    <= salinity;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    exp_item = predict_solubility(temperature, salinity);
    if (clamp_known && exp_item.temp_clamped != (temperature > 15'sd10240)) begin
      $display("predictor clamp flag wrong for t=%0d", temperature);
      mismatches++;
    end
    expected_q.push_back(exp_item);
    sent++;
  endtask

  task automatic idle_gap();
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      smp.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample side: directed table, then random samples
  initial begin
    logic signed [14:0] t;
    logic        [13:0] s;
    rst             = 1'b1;
    smp.valid       = 1'b0;
    smp.temperature = '0;
    smp.salinity    = '0;
    mismatches      = 0;
    sent            = 0;
    calm            = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      idle_gap();
      send_sample(dir_rows[i].temperature, dir_rows[i].salinity, dir_rows[i].clamp_known);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i >= CALM_FROM) calm = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        // full field range, beyond the nominal limits
        t = 15'($urandom_range(0, 32767));
        s = 14'($urandom_range(0, 16383));
      end else begin
        t = 15'($urandom_range(0, 17663) - 1280);
        s = 14'($urandom_range(0, 12800));
      end
      idle_gap();
      send_sample(t, s, 1'b1);
    end
    smp.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("oxygen_solubility_seawater_core_tb: done, clean");
    end else begin
      $display("oxygen_solubility_seawater_core_tb: done, errors");
    end
    $finish;
  end

  // Long receiver hold-off, counted here once enough samples went in
  initial begin
    holdoff = 1'b0;
    wait (sent >= HOLDOFF_AT);
    @(posedge clk);
    holdoff = 1'b1;
    repeat (HOLDOFF_LEN) @(posedge clk);
    holdoff = 1'b0;
  end

  // Result side: random ready bursts, long hold-off, compare each transfer
  initial begin
    solubility_t want;
    int stall_left;
    received     = 0;
    stall_left   = 0;
    res.ready    = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) begin
        received++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: saturation=%0d clamp=%0b",
                     res.saturation, res.temp_clamped);
        end else begin
          want = expected_q.pop_front();
          if (res.saturation !== want.saturation || res.temp_clamped !== want.temp_clamped)
          begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch at result %0d: saturation exp %0d got %0d, clamp exp %0b got %0b",
                       received, want.saturation, res.saturation,
                       want.temp_clamped, res.temp_clamped);
          end
        end
      end
      // pick ready for the next edge
      if (holdoff) begin
        res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((smp.valid && smp.ready) || (res.valid && res.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("oxygen_solubility_seawater_core_tb: done, errors");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

>>> oxygen_solubility_seawater_core.f
design/oss_pkg.sv
design/oss_in_if.sv
design/oss_out_if.sv
design/oss_exp.sv
design/oxygen_solubility_seawater_core.sv
tb/oxygen_solubility_seawater_core_tb.sv
